>>> hdl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants for the bounded ordered list
// Operation codes, sequencer states and default sizing.
// ----------------------------------------------------------------------------
package bol_pkg;

  // default list capacity
  localparam int CAPACITY_DEF = 16;

  // payload widths
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int OUT_TDATA_W = 8;

  // operation codes carried on in_tuser
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_CHK,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

endpackage

>>> hdl/bounded_ordered_list.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list: newest-first list of signed 32-bit values
// Insert at head, search, remove first match from head, clear. One result
// transaction per input transaction with found, full_refused and entry_count.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                           | tuser
//  --------+-----------+---------------------------------+-----------
//  in_     | slave     | [31:0] value                    | [1:0] op
//  out_    | master    | [0] found [1] full_refused      | -
//          |           | [6:2] entry_count [7] zero      |
//
//  Steps: insert and clear go from accept to the final state. Search and
//  remove scan from the head, a read and a compare state per entry.
//  A remove that matches then moves each entry after the match one place
//  toward the tail, a check and a write state per entry, and settles the
//  count in a last check state. The value memory has one read port.
//  Reset clears count, state and out_valid; memory needs no clearing pass.
//  The next input is taken once the result sits in the output register;
//  a stalled output holds the sequencer in its final state.
//
module bounded_ordered_list #(
  parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bol_pkg::VALUE_W-1:0]     in_tdata,   // [31:0] value
  input  logic [1:0]                      in_tuser,   // [1:0] op
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bol_pkg::OUT_TDATA_W-1:0] out_tdata   // found, full_refused, entry_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Physical layout: entry 0 is the oldest (tail), entry count-1 the head.

  // registers
  bol_pkg::state_t               state_r, state_nxt;
  bol_pkg::op_t                  op_r, op_nxt;
  logic [bol_pkg::VALUE_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic                          found_r, found_nxt;
  logic                          refused_r, refused_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic                          out_refused_r, out_refused_nxt;
  logic [bol_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic [bol_pkg::VALUE_W-1:0]   rd_data_r;

  // memory port
  logic [bol_pkg::VALUE_W-1:0]   mem [CAPACITY];
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [bol_pkg::VALUE_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]              rd_addr;

  // helpers
  logic                          in_fire;
  logic                          out_free;
  logic [CNT_W-1:0]              idx_plus1;
  logic [CNT_W+bol_pkg::COUNT_W-1:0] count_ext;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign idx_plus1 = CNT_W'(idx_r) + CNT_W'(1);
  assign count_ext = {{bol_pkg::COUNT_W{1'b0}}, count_r};

  // value memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bol_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    key_r         <= key_nxt;
    idx_r         <= idx_nxt;
    found_r       <= found_nxt;
    refused_r     <= refused_nxt;
    out_found_r   <= out_found_nxt;
    out_refused_r <= out_refused_nxt;
    out_count_r   <= out_count_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    found_nxt       = found_r;
    refused_nxt     = refused_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_found_nxt   = out_found_r;
    out_refused_nxt = out_refused_r;
    out_count_nxt   = out_count_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    mem_wdata       = rd_data_r;
    rd_addr         = idx_r;
    in_tready       = (state_r == bol_pkg::ST_IDLE);

    unique case (state_r)
      bol_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_nxt      = bol_pkg::op_t'(in_tuser);
          key_nxt     = in_tdata;
          found_nxt   = 1'b0;
          refused_nxt = 1'b0;
          unique case (bol_pkg::op_t'(in_tuser))
            bol_pkg::OP_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                refused_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(count_r);
                mem_wdata = in_tdata;
                count_nxt = count_r + CNT_W'(1);
              end
              state_nxt = bol_pkg::ST_DONE;
            end
            bol_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = bol_pkg::ST_DONE;
            end
            default: begin
              // search or remove: scan from the head downward
              if (count_r == '0) begin
                state_nxt = bol_pkg::ST_DONE;
              end else begin
                idx_nxt   = IDX_W'(count_r - CNT_W'(1));
                state_nxt = bol_pkg::ST_SCAN_RD;
              end
            end
          endcase
        end
      end

      bol_pkg::ST_SCAN_RD: begin
        rd_addr   = idx_r;
        state_nxt = bol_pkg::ST_SCAN_CMP;
      end

      bol_pkg::ST_SCAN_CMP: begin
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          state_nxt = (op_r == bol_pkg::OP_REMOVE) ? bol_pkg::ST_SHIFT_CHK
                                                   : bol_pkg::ST_DONE;
        end else if (idx_r == '0) begin
          state_nxt = bol_pkg::ST_DONE;
        end else begin
          idx_nxt   = idx_r - IDX_W'(1);
          state_nxt = bol_pkg::ST_SCAN_RD;
        end
      end

      // close the gap: move each newer entry one place toward the tail
      bol_pkg::ST_SHIFT_CHK: begin
        if (idx_plus1 < count_r) begin
          rd_addr   = IDX_W'(idx_plus1);
          state_nxt = bol_pkg::ST_SHIFT_WR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = bol_pkg::ST_DONE;
        end
      end

      bol_pkg::ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = rd_data_r;
        idx_nxt   = IDX_W'(idx_plus1);
        state_nxt = bol_pkg::ST_SHIFT_CHK;
      end

      bol_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_found_nxt   = found_r;
          out_refused_nxt = refused_r;
          out_count_nxt   = count_ext[bol_pkg::COUNT_W-1:0];
          state_nxt       = bol_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bol_pkg::ST_IDLE;
      end
    endcase
  end

  // result port
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_refused_r, out_found_r};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bol_pkg::ST_DONE))
    else $error("result raised outside final state");

  a_refused_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_refused_r |-> !out_found_r)
    else $error("refused insert reports a match");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser == bol_pkg::OP_CLEAR) |=> count_r == '0)
    else $error("clear left entries");

  a_shift_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bol_pkg::ST_SHIFT_WR) |-> (op_r == bol_pkg::OP_REMOVE) && found_r)
    else $error("entry move outside a matched remove");

endmodule
